// ===== src/mvm_pkg.sv =====
// Package for the matrix-vector multiply unit: sizes, codes, state type
// and small helper functions shared by the RTL. No dependencies.

package mvm_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int VEC_DEPTH = 16;
    localparam int DIM_LIMIT = 16;

    localparam int IDX_W  = 4;
    localparam int DIM_W  = 5;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int MAT_AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
    localparam int VEC_AW = $clog2(VEC_DEPTH);

    // func codes
    localparam logic [1:0] FUNC_LOAD_MAT = 2'd0;
    localparam logic [1:0] FUNC_LOAD_VEC = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // zero counts as one, then clamp to the smaller of the parameter and 16
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                   input int maxp);
        int lim;
        logic [DIM_W-1:0] r;
        lim = (maxp < DIM_LIMIT) ? maxp : DIM_LIMIT;
        r = (d == '0) ? DIM_W'(1) : d;
        if (int'(r) > lim)
            r = DIM_W'(lim);
        return r;
    endfunction

    function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return MAT_AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

endpackage

// ===== src/matrix_vector_multiply_unit.sv =====
// Matrix-vector multiply unit: matrix and vector stores, one shared 32x32
// multiplier with a saturating 64-bit accumulator, and its sequencer.
// Depends on mvm_pkg.

// Usage
//   Input channel (in_valid/in_ready): each beat carries func, row_index,
//   col_index and value. func 0 writes a matrix entry, func 1 a vector
//   entry; both are written on acceptance and give no result. func 2 runs the
//   product; func 3 is dropped.
//   Output channel (out_valid/out_ready): one beat per product element in
//   index order, Q32.32 sum, sticky saturation flag, last on the final one.
//   Config port (cfg_we/cfg_index/cfg_data): write only while idle.
// Timing
//   A compute beat feeds each output element's terms through the shared
//   multiplier at one term per cycle, drains the store read and multiply
//   pipeline registers into the accumulator, then loads the output
//   register. in_ready is low for the whole compute.
//   The last result may wait in the output register while new loads are
//   taken; any element waits while the output register is still full.
// Reset
//   rst_n clears control state and sets rows/cols to 16, normal mode.
//   Store contents are undefined until written.

module matrix_vector_multiply_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [mvm_pkg::IDX_W-1:0]           row_index,
    input  logic [mvm_pkg::IDX_W-1:0]           col_index,
    input  logic signed [mvm_pkg::DATA_W-1:0]   value,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mvm_pkg::IDX_W-1:0]           out_index,
    output logic signed [mvm_pkg::ACC_W-1:0]    out_value,
    output logic                                saturated,
    output logic                                last,
    // config port
    input  logic                                cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvm_pkg::CFG_DAT_W-1:0]       cfg_data
);

    // ---------------- config registers ----------------
    logic [mvm_pkg::DIM_W-1:0] rows_reg;
    logic [mvm_pkg::DIM_W-1:0] cols_reg;
    logic                      transpose_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= mvm_pkg::DIM_W'(16);
            cols_reg      <= mvm_pkg::DIM_W'(16);
            transpose_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvm_pkg::CFG_ROWS:      rows_reg      <= cfg_data;
                mvm_pkg::CFG_COLS:      cols_reg      <= cfg_data;
                mvm_pkg::CFG_TRANSPOSE: transpose_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    mvm_pkg::state_t state_reg, state_next;

    logic [mvm_pkg::DIM_W-1:0] n_reg, n_next;   // output elements
    logic [mvm_pkg::DIM_W-1:0] m_reg, m_next;   // terms per element
    logic [mvm_pkg::IDX_W-1:0] i_reg, i_next;   // element counter
    logic [mvm_pkg::IDX_W-1:0] j_reg, j_next;   // term counter

    logic in_fire, start, issue, out_load;
    logic j_last, i_last;
    logic rd_valid_reg, rd_last_reg;
    logic prod_valid_reg, prod_last_reg;

    assign in_fire = in_valid && in_ready;
    assign start   = in_fire && (func == mvm_pkg::FUNC_COMPUTE);
    assign j_last  = ({1'b0, j_reg} == m_reg - mvm_pkg::DIM_W'(1));
    assign i_last  = ({1'b0, i_reg} == n_reg - mvm_pkg::DIM_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvm_pkg::ST_IDLE:
                if (start)
                    state_next = mvm_pkg::ST_RUN;
            mvm_pkg::ST_RUN:
                if (j_last)
                    state_next = mvm_pkg::ST_DRAIN;
            mvm_pkg::ST_DRAIN:
                if (prod_valid_reg && prod_last_reg)
                    state_next = mvm_pkg::ST_OUT;
            mvm_pkg::ST_OUT:
                if (out_load)
                    state_next = i_last ? mvm_pkg::ST_IDLE : mvm_pkg::ST_RUN;
            default:
                state_next = mvm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            mvm_pkg::ST_IDLE:  in_ready = 1'b1;
            mvm_pkg::ST_RUN:   issue    = 1'b1;
            mvm_pkg::ST_DRAIN: ;
            mvm_pkg::ST_OUT:   out_load = !out_valid || out_ready;
            default: ;
        endcase
    end

    always_comb
    begin
        n_next = n_reg;
        m_next = m_reg;
        i_next = i_reg;
        j_next = j_reg;
        if (start)
        begin
            // dimensions of the product, fixed for this compute
            n_next = transpose_reg ? mvm_pkg::clamp_dim(cols_reg, mvm_pkg::MAX_COLS)
                                   : mvm_pkg::clamp_dim(rows_reg, mvm_pkg::MAX_ROWS);
            m_next = transpose_reg ? mvm_pkg::clamp_dim(rows_reg, mvm_pkg::MAX_ROWS)
                                   : mvm_pkg::clamp_dim(cols_reg, mvm_pkg::MAX_COLS);
            i_next = '0;
            j_next = '0;
        end
        else if (issue)
            j_next = j_last ? '0 : j_reg + mvm_pkg::IDX_W'(1);
        else if (out_load)
            i_next = i_reg + mvm_pkg::IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mvm_pkg::ST_IDLE;
            n_reg          <= '0;
            m_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            m_reg          <= m_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            rd_valid_reg   <= issue;
            rd_last_reg    <= issue && j_last;
            prod_valid_reg <= rd_valid_reg;
            prod_last_reg  <= rd_last_reg;
        end
    end

    // ---------------- stores ----------------
    logic [mvm_pkg::DATA_W-1:0] matrix_mem [mvm_pkg::MAX_ROWS * mvm_pkg::MAX_COLS];
    logic [mvm_pkg::DATA_W-1:0] vector_mem [mvm_pkg::VEC_DEPTH];

    logic                       mat_we, vec_we;
    logic [mvm_pkg::MAT_AW-1:0] mat_waddr, mat_raddr;
    logic [mvm_pkg::IDX_W-1:0]  row_sel, col_sel;
    logic signed [mvm_pkg::DATA_W-1:0] mat_rd_reg, vec_rd_reg;

    // out-of-range matrix loads are dropped
    assign mat_we    = in_fire && (func == mvm_pkg::FUNC_LOAD_MAT)
                       && (int'(row_index) < mvm_pkg::MAX_ROWS)
                       && (int'(col_index) < mvm_pkg::MAX_COLS);
    assign vec_we    = in_fire && (func == mvm_pkg::FUNC_LOAD_VEC);
    assign mat_waddr = mvm_pkg::mat_addr(row_index, col_index);

    // normal: M[i][j]; transpose: M[j][i]
    assign row_sel   = transpose_reg ? j_reg : i_reg;
    assign col_sel   = transpose_reg ? i_reg : j_reg;
    assign mat_raddr = mvm_pkg::mat_addr(row_sel, col_sel);

    always_ff @(posedge clk)
    begin
        if (mat_we)
            matrix_mem[mat_waddr] <= value;
        if (vec_we)
            vector_mem[row_index[mvm_pkg::VEC_AW-1:0]] <= value;
    end

    always_ff @(posedge clk)
    begin
        mat_rd_reg <= matrix_mem[mat_raddr];
        vec_rd_reg <= vector_mem[j_reg[mvm_pkg::VEC_AW-1:0]];
    end

    // ---------------- multiply and accumulate ----------------
    logic signed [mvm_pkg::ACC_W-1:0] prod_reg;
    logic signed [mvm_pkg::ACC_W-1:0] acc_reg, acc_next, sum;
    logic                             sat_reg, sat_next, ovf;

    // operands sign-extended to the product width; a 32x32 signed multiply
    always_ff @(posedge clk)
    begin
        prod_reg <= mvm_pkg::ACC_W'(mat_rd_reg) * mvm_pkg::ACC_W'(vec_rd_reg);
    end

    assign sum = acc_reg + prod_reg;
    assign ovf = (acc_reg[mvm_pkg::ACC_W-1] == prod_reg[mvm_pkg::ACC_W-1])
                 && (sum[mvm_pkg::ACC_W-1] != acc_reg[mvm_pkg::ACC_W-1]);

    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (start || out_load)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
        else if (prod_valid_reg)
        begin
            if (ovf)
            begin
                // clamp and keep going from the rail
                acc_next = acc_reg[mvm_pkg::ACC_W-1]
                           ? {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}}
                           : {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
                sat_next = 1'b1;
            end
            else
                acc_next = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_reg <= 1'b0;
        else
            sat_reg <= sat_next;
    end

    // ---------------- output register ----------------
    logic out_valid_reg;
    logic [mvm_pkg::IDX_W-1:0]        out_index_reg;
    logic signed [mvm_pkg::ACC_W-1:0] out_value_reg;
    logic                             out_sat_reg, out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= i_reg;
            out_value_reg <= acc_reg;
            out_sat_reg   <= sat_reg;
            out_last_reg  <= i_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign saturated = out_sat_reg;
    assign last      = out_last_reg;

    // ---------------- assertions ----------------
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == mvm_pkg::ST_RUN))
        else $error("compute beat did not start the sequencer");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mvm_pkg::ST_RUN) |-> ({1'b0, j_reg} < m_reg))
        else $error("term counter ran past the element length");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> (state_reg == mvm_pkg::ST_RUN || state_reg == mvm_pkg::ST_DRAIN))
        else $error("product arrived outside a compute");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && i_last) |=> (state_reg == mvm_pkg::ST_IDLE && out_valid && last))
        else $error("final element did not end the compute");

endmodule

// ===== bench/mvm_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for matrix_vector_multiply_unit: tracks register writes and
// input beats, predicts every product element and compares output beats.
// Depends on mvm_pkg.

module mvm_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [mvm_pkg::IDX_W-1:0]         row_index,
    input  logic [mvm_pkg::IDX_W-1:0]         col_index,
    input  logic signed [mvm_pkg::DATA_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [mvm_pkg::IDX_W-1:0]         out_index,
    input  logic signed [mvm_pkg::ACC_W-1:0]  out_value,
    input  logic                              saturated,
    input  logic                              last,
    input  logic                              cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mvm_pkg::CFG_DAT_W-1:0]     cfg_data,
    output int                                error_count,
    output int                                expected_left,
    output int                                result_count,
    output int                                sat_count
);

    import mvm_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [ACC_W-1:0] total;
        logic                    sat;
        logic                    last;
    } elem_t;

    // shadow copies of the stores and registers
    logic [DATA_W-1:0] mat_copy [MAX_ROWS*MAX_COLS];
    logic [DATA_W-1:0] vec_copy [VEC_DEPTH];
    logic [DIM_W-1:0]  rows_cfg;
    logic [DIM_W-1:0]  cols_cfg;
    logic              trans_cfg;

    elem_t pending_elems [$];
    elem_t seen;
    int    errs;
    int    results;
    int    sats;

    // 0 acts as 1, anything past the store size is cut back to it
    function automatic int used_dim(input logic [DIM_W-1:0] d, input int maxp);
        int lim;
        int r;
        lim = (maxp < 16) ? maxp : 16;
        r = (d == '0) ? 1 : int'(d);
        return (r > lim) ? lim : r;
    endfunction

    // one expected element per output index, saturating at every add
    task automatic predict_product();
        int n;
        int m;
        logic [DATA_W-1:0]       me;
        logic [DATA_W-1:0]       ve;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] term;
        logic signed [ACC_W-1:0] total;
        logic                    hit;
        elem_t                   e;
        n = trans_cfg ? used_dim(cols_cfg, MAX_COLS) : used_dim(rows_cfg, MAX_ROWS);
        m = trans_cfg ? used_dim(rows_cfg, MAX_ROWS) : used_dim(cols_cfg, MAX_COLS);
        for (int i = 0; i < n; i++) begin
            acc = '0;
            hit = 1'b0;
            for (int j = 0; j < m; j++) begin
                me = trans_cfg ? mat_copy[j*MAX_COLS + i] : mat_copy[i*MAX_COLS + j];
                ve = vec_copy[j];
                a = {{(ACC_W-DATA_W){me[DATA_W-1]}}, me};
                b = {{(ACC_W-DATA_W){ve[DATA_W-1]}}, ve};
                term = a * b;
                total = acc + term;
                if (acc[ACC_W-1] == term[ACC_W-1] && total[ACC_W-1] != acc[ACC_W-1]) begin
                    hit = 1'b1;
                    acc = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
                end else begin
                    acc = total;
                end
            end
            e.index = IDX_W'(i);
            e.total = acc;
            e.sat   = hit;
            e.last  = (i == n - 1);
            pending_elems.push_back(e);
            if (hit)
                sats++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rows_cfg  = 5'd16;
            cols_cfg  = 5'd16;
            trans_cfg = 1'b0;
            pending_elems.delete();
            errs      = 0;
            results   = 0;
            sats      = 0;
        end else begin
            if (out_valid && out_ready) begin
                results++;
                if (pending_elems.size() == 0) begin
                    $error("result beat with nothing expected: out_index %0d out_value %0d",
                           out_index, out_value);
                    errs++;
                end else begin
                    seen = pending_elems.pop_front();
                    if (out_index !== seen.index) begin
                        $error("out_index: expected %0d, got %0d", seen.index, out_index);
                        errs++;
                    end
                    if (out_value !== seen.total) begin
                        $error("out_value: expected %0d, got %0d", seen.total, out_value);
                        errs++;
                    end
                    if (saturated !== seen.sat) begin
                        $error("saturated: expected %0b, got %0b", seen.sat, saturated);
                        errs++;
                    end
                    if (last !== seen.last) begin
                        $error("last: expected %0b, got %0b", seen.last, last);
                        errs++;
                    end
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROWS:      rows_cfg = cfg_data;
                    CFG_COLS:      cols_cfg = cfg_data;
                    CFG_TRANSPOSE: trans_cfg = cfg_data[0];
                    default:       ;
                endcase
            end

            if (in_valid && in_ready) begin
                case (func)
                    FUNC_LOAD_MAT: mat_copy[int'(row_index)*MAX_COLS + int'(col_index)] = value;
                    FUNC_LOAD_VEC: vec_copy[row_index] = value;
                    FUNC_COMPUTE:  predict_product();
                    default:       ;
                endcase
            end
        end
        // counters go out through nonblocking updates so the stimulus side
        // never races with them
        error_count   <= errs;
        expected_left <= pending_elems.size();
        result_count  <= results;
        sat_count     <= sats;
    end

endmodule

// ===== bench/matrix_vector_multiply_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the matrix_vector_multiply_unit bench: clock, reset, stimulus and
// verdict. Depends on mvm_pkg, the unit itself and mvm_result_checker.

module matrix_vector_multiply_unit_tb;

    import mvm_pkg::*;

    localparam int ITEM_TARGET   = 430;
    localparam int HOLD_CYCLES   = 400;     // long output hold-off, done once
    localparam int SETTLE_CYCLES = 10;      // quiet time before a register write
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 500_000;

    // codes the package has no name for
    localparam logic [1:0]           FUNC_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                func = '0;
    logic [IDX_W-1:0]          row_index = '0;
    logic [IDX_W-1:0]          col_index = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [IDX_W-1:0]          out_index;
    logic signed [ACC_W-1:0]   out_value;
    logic                      saturated;
    logic                      last;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DAT_W-1:0]      cfg_data = '0;

    int chk_errors;
    int chk_left;
    int chk_results;
    int chk_sats;

    // stimulus bookkeeping
    bit mat_written [MAX_ROWS*MAX_COLS];
    bit vec_written [VEC_DEPTH];
    int eff_rows = 16;
    int eff_cols = 16;
    bit trans_now = 1'b0;
    int items_sent = 0;
    int products_run = 0;
    int shapes = 0;
    int burst_left = 0;
    bit hold_wanted = 1'b0;
    bit hold_done = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    matrix_vector_multiply_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .row_index (row_index),
        .col_index (col_index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_index (out_index),
        .out_value (out_value),
        .saturated (saturated),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mvm_result_checker result_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_index     (out_index),
        .out_value     (out_value),
        .saturated     (saturated),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (chk_errors),
        .expected_left (chk_left),
        .result_count  (chk_results),
        .sat_count     (chk_sats)
    );

    // Q16.16 values weighted toward the extremes so that sums of a few
    // products overflow the Q32.32 accumulator in both directions
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = 32'h7FFF_FFFF;
            2, 3:    v = 32'h8000_0000;
            4:       v = 32'($urandom_range(0, 32'h2_0000) - 32'h1_0000);
            5:       v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // register value for a dimension: mostly small, with 0, 16 and
    // out-of-range codes mixed in
    function automatic logic [CFG_DAT_W-1:0] pick_dim();
        logic [CFG_DAT_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = CFG_DAT_W'($urandom_range(17, 31));
            2:       d = 5'd16;
            default: d = CFG_DAT_W'($urandom_range(1, 6));
        endcase
        return d;
    endfunction

    // Offer one beat and hold it until taken. Bursts of back-to-back beats
    // alternate with gaps; valid only drops when a gap really follows.
    task automatic send_beat(input logic [1:0] f, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
        int gap;
        in_valid  <= 1'b1;
        func      <= f;
        row_index <= r;
        col_index <= c;
        value     <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (f == FUNC_LOAD_MAT)
            mat_written[int'(r)*MAX_COLS + int'(c)] = 1'b1;
        if (f == FUNC_LOAD_VEC)
            vec_written[r] = 1'b1;
        if (f != FUNC_NONE)
            items_sent++;
        if (f == FUNC_COMPUTE)
            products_run++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
            burst_left = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A product may only read entries that were written: load whatever the
    // current shape still lacks, then issue the compute beat.
    task automatic send_compute();
        int need_vec;
        need_vec = trans_now ? eff_rows : eff_cols;
        for (int r = 0; r < eff_rows; r++)
            for (int c = 0; c < eff_cols; c++)
                if (!mat_written[r*MAX_COLS + c])
                    send_beat(FUNC_LOAD_MAT, IDX_W'(r), IDX_W'(c), pick_value());
        for (int j = 0; j < need_vec; j++)
            if (!vec_written[j])
                send_beat(FUNC_LOAD_VEC, IDX_W'(j), IDX_W'($urandom_range(0, 15)), pick_value());
        send_beat(FUNC_COMPUTE, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                  $urandom());
    endtask

    // Stop offering, wait for every predicted element, then give the unit
    // time to finish any load still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers back to back; write enable stays high
    // across them and drops once at the end.
    task automatic program_shape(input logic [CFG_DAT_W-1:0] r, input logic [CFG_DAT_W-1:0] c,
                                 input logic [CFG_DAT_W-1:0] t, input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= c;
        @(posedge clk);
        cfg_index <= CFG_TRANSPOSE;
        cfg_data  <= t;
        @(posedge clk);
        if (poke_spare) begin
            // index with no register behind it: must change nothing
            cfg_index <= CFG_SPARE;
            cfg_data  <= CFG_DAT_W'($urandom());
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        eff_rows  = (r == '0) ? 1 : ((int'(r) > MAX_ROWS) ? MAX_ROWS : int'(r));
        eff_cols  = (c == '0) ? 1 : ((int'(c) > MAX_COLS) ? MAX_COLS : int'(c));
        trans_now = t[0];
        shapes++;
    endtask

    // Output side: segments of always-ready, mostly-ready, mostly-stalled
    // and a one-in-three pattern. When the stimulus asks for it, one long
    // hold-off lets the result register fill and back up the input.
    initial
    begin : receiver
        int seg;
        int mode;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_wanted && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(16, 160);
            for (int k = 0; k < seg && !(hold_wanted && !hold_done); k++) begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (k % 3 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int ops;
        int pick;
        logic [CFG_DAT_W-1:0] r_cfg;
        logic [CFG_DAT_W-1:0] c_cfg;
        logic [CFG_DAT_W-1:0] t_cfg;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // 2x3 shape. Row 0 pairs two most-negative terms (positive overflow,
        // then a negative term pulls back from the clamp: flag must stick);
        // row 1 lands just inside the negative range.
        program_shape(5'd2, 5'd3, 5'd0, 1'b1);
        send_beat(FUNC_LOAD_MAT, 4'd0, 4'd0, 32'h8000_0000);
        send_beat(FUNC_LOAD_MAT, 4'd0, 4'd1, 32'h8000_0000);
        send_beat(FUNC_LOAD_MAT, 4'd0, 4'd2, 32'h8000_0000);
        send_beat(FUNC_LOAD_MAT, 4'd1, 4'd0, 32'h7FFF_FFFF);
        send_beat(FUNC_LOAD_MAT, 4'd1, 4'd1, 32'h7FFF_FFFF);
        send_beat(FUNC_LOAD_MAT, 4'd1, 4'd2, 32'h0000_0001);
        send_beat(FUNC_LOAD_VEC, 4'd0, 4'd15, 32'h8000_0000);
        send_beat(FUNC_LOAD_VEC, 4'd1, 4'd0, 32'h8000_0000);
        send_beat(FUNC_LOAD_VEC, 4'd2, 4'd7, 32'h7FFF_FFFF);
        // top corners of both stores, plus an unused func that must vanish
        send_beat(FUNC_LOAD_MAT, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_beat(FUNC_LOAD_VEC, 4'd15, 4'd15, 32'h0001_0000);
        send_beat(FUNC_NONE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_compute();
        wait_idle();
        // same data, vector times matrix: three elements of two terms
        program_shape(5'd2, 5'd3, 5'd1, 1'b0);
        send_compute();
        wait_idle();
        // zero dimensions behave as one: a single-term, single-element product
        program_shape(5'd0, 5'd0, 5'd0, 1'b0);
        send_compute();

        // --- random phases ---
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            phase++;
            case (phase)
                2:       begin r_cfg = 5'd16; c_cfg = 5'd16; t_cfg = 5'd0; end
                4:       begin r_cfg = 5'd31; c_cfg = 5'd0;  t_cfg = 5'd1; end
                6:       begin r_cfg = 5'd0;  c_cfg = 5'd31; t_cfg = 5'd1; end
                8:       begin r_cfg = 5'd16; c_cfg = 5'd31; t_cfg = 5'd1; end
                default: begin
                    r_cfg = pick_dim();
                    c_cfg = pick_dim();
                    t_cfg = ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom())
                                                        : CFG_DAT_W'($urandom_range(0, 1));
                end
            endcase
            program_shape(r_cfg, c_cfg, t_cfg, phase == 3);
            if (phase == 1) begin
                // receiver goes quiet now; these products pile up behind it
                hold_wanted = 1'b1;
                repeat (4) send_compute();
            end
            ops = $urandom_range(6, 30);
            repeat (ops) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    if ($urandom_range(0, 3) != 0)
                        send_beat(FUNC_LOAD_MAT, IDX_W'($urandom_range(0, eff_rows - 1)),
                                  IDX_W'($urandom_range(0, eff_cols - 1)), pick_value());
                    else
                        send_beat(FUNC_LOAD_MAT, IDX_W'($urandom_range(0, 15)),
                                  IDX_W'($urandom_range(0, 15)), pick_value());
                end else if (pick < 62) begin
                    send_beat(FUNC_LOAD_VEC, IDX_W'($urandom_range(0, 15)),
                              IDX_W'($urandom_range(0, 15)), pick_value());
                end else if (pick < 95) begin
                    send_compute();
                end else begin
                    send_beat(FUNC_NONE, IDX_W'($urandom_range(0, 15)),
                              IDX_W'($urandom_range(0, 15)), $urandom());
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run: %0d input beats over %0d shapes, %0d products computed.",
                 items_sent, shapes, products_run);
        $display("Run: %0d result beats checked, %0d of them saturated.",
                 chk_results, chk_sats);
        if (chk_errors == 0 && chk_left == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
